// ===== rtl/bfl_pkg.sv =====
// ----------------------------------------------------------------------------
// bfl_pkg: shared types and constants for the best-fit free block list
// Entry layout, status codes and widths used by the list and its compare unit.
// ----------------------------------------------------------------------------
package bfl_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int TYPE_W   = 8;
    localparam int ROW_W    = 48;
    localparam int SIZE_W   = 24;
    localparam int STAT_W   = 3;

    typedef struct packed {
        logic [TYPE_W-1:0] block_type;
        logic [ROW_W-1:0]  row;
        logic [SIZE_W-1:0] size;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // compare unit verdict on one stored entry
    typedef struct packed {
        logic              key_match;
        logic              size_diff;
        logic              better;
        logic [SIZE_W-1:0] tail;
    } cmp_res_t;

    localparam logic FUNC_PUT = 1'b0;
    localparam logic FUNC_GET = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNCHANGED = 3'd2;
    localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STAT_W-1:0] ST_ABSENT    = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd6;
    localparam logic [STAT_W-1:0] ST_NONE      = 3'd7;

endpackage

// ===== rtl/bfl_ram.sv =====
// ----------------------------------------------------------------------------
// bfl_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/bfl_cmp.sv =====
// ----------------------------------------------------------------------------
// bfl_cmp: shared compare unit
// Checks one stored entry against the current word: key match for put,
// fit and surplus against the running best for get.
// ----------------------------------------------------------------------------
module bfl_cmp
    import bfl_pkg::*;
(
    input  entry_t            entry,
    input  logic [TYPE_W-1:0] key_type,
    input  logic [ROW_W-1:0]  key_row,
    input  logic [SIZE_W-1:0] req_size,
    input  logic              have_best,
    input  logic [SIZE_W-1:0] best_tail,
    output cmp_res_t          res
);

    logic            type_hit;
    logic [SIZE_W:0] diff;

    always_comb
    begin
        type_hit      = (entry.block_type == key_type);
        diff          = {1'b0, entry.size} - {1'b0, req_size};
        res.key_match = type_hit && (entry.row == key_row);
        res.size_diff = (entry.size != req_size);
        res.tail      = diff[SIZE_W-1:0];
        // no borrow means the entry fits; strict less keeps the earliest on ties
        res.better    = type_hit && !diff[SIZE_W]
                        && (!have_best || (diff[SIZE_W-1:0] < best_tail));
    end

endmodule

// ===== rtl/best_fit_free_block_list.sv =====
// ----------------------------------------------------------------------------
// best_fit_free_block_list: bounded free block list with best-fit lookup
// Scans a RAM of free blocks in insertion order with one compare unit.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word: func, block_type, row_key,
// size_value. A put (func 0) updates, appends or removes the block keyed by
// type and row id; a get (func 1) reports the block of that type with the
// smallest surplus over the request, the earliest on ties.
// Output channel (out_valid/out_ready) returns one word per input: status,
// found_row, found_size.
// Timing: entries are read from the RAM one a cycle and checked by the
// shared compare unit. A get, or a put whose key is not in the list, scans
// the whole list before its result is ready; a put that hits a slot stops
// the scan there. A remove then moves each later entry up one slot, one a
// cycle. in_ready is high only while the sequencer is idle; the next word
// can be taken once the result is loaded into the output register.
// Reset empties the list at once (count cleared, no clearing pass) and drops
// any pending result. If the receiver stalls, the finished result waits in
// the output register; the next word is still taken, and its result is held
// until the output register frees up.
// ----------------------------------------------------------------------------
module best_fit_free_block_list
    import bfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    input  logic [TYPE_W-1:0] block_type,
    input  logic [ROW_W-1:0]  row_key,
    input  logic [SIZE_W-1:0] size_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] status,
    output logic [ROW_W-1:0]  found_row,
    output logic [SIZE_W-1:0] found_size
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              func_reg, func_next;
    logic [TYPE_W-1:0] type_reg, type_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              have_reg, have_next;
    logic [SIZE_W-1:0] best_tail_reg, best_tail_next;
    logic [ROW_W-1:0]  best_row_reg, best_row_next;
    logic [SIZE_W-1:0] best_size_reg, best_size_next;
    logic [STAT_W-1:0] pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [ROW_W-1:0]  found_row_reg, found_row_next;
    logic [SIZE_W-1:0] found_size_reg, found_size_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    entry_t            ram_rdata;
    cmp_res_t          cmp;

    bfl_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(addr_reg[IDX_W-1:0]),
        .rdata(ram_rdata)
    );

    bfl_cmp u_cmp (
        .entry    (ram_rdata),
        .key_type (type_reg),
        .key_row  (row_reg),
        .req_size (size_reg),
        .have_best(have_reg),
        .best_tail(best_tail_reg),
        .res      (cmp)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign found_row  = found_row_reg;
    assign found_size = found_size_reg;

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        type_next       = type_reg;
        row_next        = row_reg;
        size_next       = size_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = addr_reg[IDX_W-1:0];
        have_next       = have_reg;
        best_tail_next  = best_tail_reg;
        best_row_next   = best_row_reg;
        best_size_next  = best_size_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        found_row_next  = found_row_reg;
        found_size_next = found_size_reg;
        ram_we          = 1'b0;
        ram_waddr       = rd_idx_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    type_next  = block_type;
                    row_next   = row_key;
                    size_next  = size_value;
                    addr_next  = '0;
                    have_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // keep reading ahead unless this cycle's entry is the put key
                if ((addr_reg < count_reg)
                    && !(rd_vld_reg && (func_reg == FUNC_PUT) && cmp.key_match))
                begin
                    ram_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    addr_next   = addr_reg + CNT_W'(1);
                end

                if (rd_vld_reg)
                begin
                    if (func_reg == FUNC_PUT)
                    begin
                        if (cmp.key_match)
                        begin
                            if (size_reg == '0)
                            begin
                                addr_next  = CNT_W'(rd_idx_reg) + CNT_W'(1);
                                state_next = S_SHIFT;
                            end
                            else if (cmp.size_diff)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = rd_idx_reg;
                                ram_wdata  = '{block_type: type_reg, row: row_reg,
                                               size: size_reg};
                                pend_next  = ST_UPDATED;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                pend_next  = ST_UNCHANGED;
                                state_next = S_FIN;
                            end
                        end
                    end
                    else if (cmp.better)
                    begin
                        have_next      = 1'b1;
                        best_tail_next = cmp.tail;
                        best_row_next  = ram_rdata.row;
                        best_size_next = ram_rdata.size;
                    end
                end
                else if (addr_reg >= count_reg)
                begin
                    // whole list seen, no key match
                    state_next = S_FIN;
                    if (func_reg == FUNC_GET)
                    begin
                        pend_next = have_reg ? ST_FOUND : ST_NONE;
                    end
                    else if (size_reg == '0)
                    begin
                        pend_next = ST_ABSENT;
                    end
                    else if (count_reg >= CNT_W'(CAPACITY))
                    begin
                        pend_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[IDX_W-1:0];
                        ram_wdata  = '{block_type: type_reg, row: row_reg, size: size_reg};
                        count_next = count_reg + CNT_W'(1);
                        pend_next  = ST_INSERTED;
                    end
                end
            end

            S_SHIFT:
            begin
                if (addr_reg < count_reg)
                begin
                    ram_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    addr_next   = addr_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_reg - IDX_W'(1);
                    ram_wdata = ram_rdata;
                end
                else if (addr_reg >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    pend_next  = ST_REMOVED;
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = pend_reg;
                    found_row_next  = (pend_reg == ST_FOUND) ? best_row_reg : '0;
                    found_size_next = (pend_reg == ST_FOUND) ? best_size_reg : '0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        type_reg       <= type_next;
        row_reg        <= row_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        rd_idx_reg     <= rd_idx_next;
        have_reg       <= have_next;
        best_tail_reg  <= best_tail_next;
        best_row_reg   <= best_row_next;
        best_size_reg  <= best_size_next;
        pend_reg       <= pend_next;
        status_reg     <= status_next;
        found_row_reg  <= found_row_next;
        found_size_reg <= found_size_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CNT_W'(1))
             || (count_reg == $past(count_reg) - CNT_W'(1))))
        else $error("entry count moved by more than one");

    a_read_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (CNT_W'(rd_idx_reg) < count_reg))
        else $error("read of a slot beyond the list");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new word taken while one is in work");
`endif

endmodule
